// ===== sv/ir_pde_pkg.sv =====
`default_nettype none

package ir_pde_pkg;

    localparam logic [16:0] GAP_US = 17'd100000;

    typedef enum logic [2:0] {
        REG_FRAME_BITS   = 3'd0,
        REG_LSB_LEAD     = 3'd1,
        REG_HEADER_MARK  = 3'd2,
        REG_HEADER_SPACE = 3'd3,
        REG_MARK_TIME    = 3'd4,
        REG_ONE_SPACE    = 3'd5,
        REG_ZERO_SPACE   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [2:0]  reg_index;
        logic [15:0] wr_data;
    } t_cfg_write;

    typedef struct packed {
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic        carrier_level;
        logic [16:0] duration_us;
        logic        frame_done;
        logic        last;
    } t_segment;

    typedef struct packed {
        logic [7:0]  frame_bits;
        logic        lsb_lead;
        logic [15:0] header_mark;
        logic [15:0] header_space;
        logic [15:0] mark_time;
        logic [15:0] one_space;
        logic [15:0] zero_space;
    } t_cfg;

endpackage

`default_nettype wire

// ===== sv/ir_pde_stream_if.sv =====
`default_nettype none

interface ir_pde_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/ir_pde_cfg.sv =====
`default_nettype none

module ir_pde_cfg
    import ir_pde_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    ir_pde_stream_if.sink   i_cfg,
    output t_cfg            o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_bits   <= 8'd32;
            r_cfg.lsb_lead     <= 1'b1;
            r_cfg.header_mark  <= 16'd0;
            r_cfg.header_space <= 16'd0;
            r_cfg.mark_time    <= 16'd560;
            r_cfg.one_space    <= 16'd1690;
            r_cfg.zero_space   <= 16'd560;
        end else if (i_cfg.valid) begin
            case (i_cfg.payload.reg_index)
                REG_FRAME_BITS:   r_cfg.frame_bits   <= i_cfg.payload.wr_data[7:0];
                REG_LSB_LEAD:     r_cfg.lsb_lead     <= i_cfg.payload.wr_data[0];
                REG_HEADER_MARK:  r_cfg.header_mark  <= i_cfg.payload.wr_data;
                REG_HEADER_SPACE: r_cfg.header_space <= i_cfg.payload.wr_data;
                REG_MARK_TIME:    r_cfg.mark_time    <= i_cfg.payload.wr_data;
                REG_ONE_SPACE:    r_cfg.one_space    <= i_cfg.payload.wr_data;
                REG_ZERO_SPACE:   r_cfg.zero_space   <= i_cfg.payload.wr_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/ir_pulse_distance_encoder.sv =====
`default_nettype none

// Infrared pulse-distance envelope encoder. Each transfer on i_in carries one
// payload byte; the block answers with 2 to 20 segments on o_out, one segment
// per cycle unless o_out.ready holds it: optional header mark and space on
// the first byte of a frame, a mark and a one/zero space per payload bit, and
// a trailing mark plus a 100000 us gap (frame_done set) when the frame bit
// count is reached. The next byte is taken in the cycle its predecessor's last
// segment moves into the output register, so segments flow without a bubble
// between bytes. The output register holds a segment while o_out.ready is
// low. Configuration writes are taken at any time and must only be issued
// while the block is idle.

module ir_pulse_distance_encoder
    import ir_pde_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ir_pde_stream_if.sink    i_cfg,
    ir_pde_stream_if.sink    i_in,
    ir_pde_stream_if.source  o_out
);

    localparam logic [9:0] LIMIT_BITS = 10'(MAX_FRAME_BYTES * 8);

    t_cfg       cfg;

    logic       r_busy;
    logic       r_out_valid;
    t_segment   r_out;
    logic [7:0] r_bit_pos;
    logic [7:0] r_byte;
    logic       r_hdr;
    logic [3:0] r_nbits;
    logic [4:0] r_seg;
    logic [4:0] r_last_seg;

    logic       out_load;
    logic       seg_last;
    logic       in_ready;
    logic       accept;

    logic [7:0] count;
    logic [7:0] rem;
    logic       over;
    logic       n_hdr;
    logic [3:0] n_nbits;
    logic       n_close;
    logic [4:0] n_last_seg;
    logic [7:0] n_bit_pos;

    logic [4:0] hdr_ofs;
    logic [4:0] j;
    logic       in_hdr;
    logic       in_bits;
    logic [2:0] k;
    logic [2:0] bit_idx;
    logic       data_bit;
    t_segment   seg;

    ir_pde_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    assign out_load    = !r_out_valid || o_out.ready;
    assign seg_last    = (r_seg == r_last_seg);
    assign in_ready    = !r_busy || (out_load && seg_last);
    assign accept      = i_in.valid && in_ready;
    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.payload = r_out;

    always_comb begin
        if ({2'b00, cfg.frame_bits} > LIMIT_BITS) begin
            count = LIMIT_BITS[7:0];
        end else begin
            count = cfg.frame_bits;
        end
        n_hdr   = (r_bit_pos == 8'd0) && (cfg.header_mark != 16'd0);
        over    = (r_bit_pos >= count);
        rem     = count - r_bit_pos;
        if (over) begin
            n_nbits = 4'd0;
        end else if (rem >= 8'd8) begin
            n_nbits = 4'd8;
        end else begin
            n_nbits = rem[3:0];
        end
        n_close    = over || (rem <= 8'd8);
        n_last_seg = {3'b000, n_hdr, 1'b0} + {n_nbits, 1'b0} + {3'b000, n_close, 1'b0}
                     - 5'd1;
        n_bit_pos  = n_close ? 8'd0 : (r_bit_pos + {4'b0000, n_nbits});
    end

    always_comb begin
        hdr_ofs  = r_hdr ? 5'd2 : 5'd0;
        j        = r_seg - hdr_ofs;
        in_hdr   = r_hdr && (r_seg < 5'd2);
        in_bits  = !in_hdr && (j < {r_nbits, 1'b0});
        k        = j[3:1];
        bit_idx  = cfg.lsb_lead ? k : (3'd7 - k);
        data_bit = r_byte[bit_idx];
        seg.last = seg_last;
        if (in_hdr) begin
            seg.carrier_level = !r_seg[0];
            seg.duration_us   = {1'b0, r_seg[0] ? cfg.header_space : cfg.header_mark};
            seg.frame_done    = 1'b0;
        end else if (in_bits) begin
            seg.carrier_level = !j[0];
            if (!j[0]) begin
                seg.duration_us = {1'b0, cfg.mark_time};
            end else begin
                seg.duration_us = {1'b0, data_bit ? cfg.one_space : cfg.zero_space};
            end
            seg.frame_done = 1'b0;
        end else begin
            seg.carrier_level = !seg_last;
            seg.duration_us   = seg_last ? GAP_US : {1'b0, cfg.mark_time};
            seg.frame_done    = seg_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_bit_pos   <= 8'd0;
        end else begin
            if (out_load) begin
                r_out_valid <= r_busy;
            end
            if (accept) begin
                r_busy    <= 1'b1;
                r_bit_pos <= n_bit_pos;
            end else if (r_busy && out_load && seg_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= seg;
        end
        if (accept) begin
            r_seg      <= 5'd0;
            r_byte     <= i_in.payload.data_byte;
            r_hdr      <= n_hdr;
            r_nbits    <= n_nbits;
            r_last_seg <= n_last_seg;
        end else if (r_busy && out_load) begin
            r_seg <= r_seg + 5'd1;
        end
    end

    a_seg_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_seg <= r_last_seg))
        else $error("segment index beyond end of byte");

    a_gap_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_done) |->
            (!r_out.carrier_level && r_out.last && (r_out.duration_us == GAP_US)))
        else $error("closing gap segment malformed");

    a_seg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !out_load) |=> ($stable(r_seg) && r_busy))
        else $error("sequencer advanced while output stalled");

    a_accept_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_busy) |-> (seg_last && out_load))
        else $error("byte taken before previous byte finished");

    a_bitpos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ({2'b00, r_bit_pos} < LIMIT_BITS))
        else $error("bit position past frame limit");

endmodule

`default_nettype wire

// ===== tb/ir_pde_envelope_check.sv =====
module ir_pde_envelope_check
    import ir_pde_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  t_cfg_write i_cfg_payload,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_item   i_in_payload,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_segment   i_out_payload,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int BIT_LIMIT = MAX_FRAME_BYTES * 8;

    t_cfg       cfg_shadow;
    logic [7:0] frame_pos;
    t_segment   expected_segments[$];
    int         fail_count = 0;

    function automatic t_segment make_seg(input logic level, input logic [16:0] dur,
                                          input logic done);
        return '{carrier_level: level, duration_us: dur, frame_done: done, last: 1'b0};
    endfunction

    task automatic encode_byte(input logic [7:0] data);
        t_segment segs[$];
        int       count;
        int       k;
        logic     bit_val;
        count = (cfg_shadow.frame_bits > BIT_LIMIT) ? BIT_LIMIT : cfg_shadow.frame_bits;
        if (frame_pos == 8'd0 && cfg_shadow.header_mark != 16'd0) begin
            segs.push_back(make_seg(1'b1, {1'b0, cfg_shadow.header_mark}, 1'b0));
            segs.push_back(make_seg(1'b0, {1'b0, cfg_shadow.header_space}, 1'b0));
        end
        for (k = 0; k < 8 && frame_pos < count; k++) begin
            bit_val = cfg_shadow.lsb_lead ? data[k] : data[7-k];
            segs.push_back(make_seg(1'b1, {1'b0, cfg_shadow.mark_time}, 1'b0));
            segs.push_back(make_seg(1'b0, bit_val ? {1'b0, cfg_shadow.one_space}
                                                  : {1'b0, cfg_shadow.zero_space}, 1'b0));
            frame_pos = frame_pos + 8'd1;
        end
        if (frame_pos >= count) begin
            segs.push_back(make_seg(1'b1, {1'b0, cfg_shadow.mark_time}, 1'b0));
            segs.push_back(make_seg(1'b0, GAP_US, 1'b1));
            frame_pos = 8'd0;
        end
        segs[segs.size()-1].last = 1'b1;
        foreach (segs[i]) expected_segments.push_back(segs[i]);
    endtask

    task automatic check_field(input string name, input logic [16:0] want,
                               input logic [16:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : track
        t_segment want;
        if (!i_rst_n) begin
            cfg_shadow = '{frame_bits: 8'd32, lsb_lead: 1'b1, header_mark: 16'd0,
                           header_space: 16'd0, mark_time: 16'd560, one_space: 16'd1690,
                           zero_space: 16'd560};
            frame_pos = 8'd0;
            expected_segments.delete();
        end else begin
            if (i_cfg_valid === 1'b1 && i_cfg_ready === 1'b1) begin
                case (i_cfg_payload.reg_index)
                    REG_FRAME_BITS:   cfg_shadow.frame_bits   = i_cfg_payload.wr_data[7:0];
                    REG_LSB_LEAD:     cfg_shadow.lsb_lead     = i_cfg_payload.wr_data[0];
                    REG_HEADER_MARK:  cfg_shadow.header_mark  = i_cfg_payload.wr_data;
                    REG_HEADER_SPACE: cfg_shadow.header_space = i_cfg_payload.wr_data;
                    REG_MARK_TIME:    cfg_shadow.mark_time    = i_cfg_payload.wr_data;
                    REG_ONE_SPACE:    cfg_shadow.one_space    = i_cfg_payload.wr_data;
                    REG_ZERO_SPACE:   cfg_shadow.zero_space   = i_cfg_payload.wr_data;
                    default: ;
                endcase
            end
            if (i_in_valid === 1'b1 && i_in_ready === 1'b1) begin
                encode_byte(i_in_payload.data_byte);
            end
            if (i_out_valid === 1'b1 && i_out_ready === 1'b1) begin
                if (expected_segments.size() == 0) begin
                    $error("unexpected segment: level %0d duration %0d done %0d last %0d",
                           i_out_payload.carrier_level, i_out_payload.duration_us,
                           i_out_payload.frame_done, i_out_payload.last);
                    fail_count++;
                end else begin
                    want = expected_segments.pop_front();
                    check_field("carrier_level", 17'(want.carrier_level),
                                17'(i_out_payload.carrier_level));
                    check_field("duration_us", want.duration_us, i_out_payload.duration_us);
                    check_field("frame_done", 17'(want.frame_done),
                                17'(i_out_payload.frame_done));
                    check_field("last", 17'(want.last), 17'(i_out_payload.last));
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_segments.size();
    end

endmodule

// ===== tb/ir_pulse_distance_encoder_tb.sv =====
module ir_pulse_distance_encoder_tb
    import ir_pde_pkg::*;
();

    localparam int         FRAME_BYTES    = 16;
    localparam int         TARGET_BYTES   = 350;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 24;
    localparam logic [2:0] REG_UNUSED     = 3'd7;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   quiet = 1'b0;
    int   bytes_sent = 0;
    int   settings_used = 0;
    int   idle_cycles = 0;

    ir_pde_stream_if #(.T(t_cfg_write)) cfg_if ();
    ir_pde_stream_if #(.T(t_in_item))   in_if ();
    ir_pde_stream_if #(.T(t_segment))   out_if ();

    ir_pulse_distance_encoder #(
        .MAX_FRAME_BYTES(FRAME_BYTES)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_if),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    ir_pde_envelope_check #(
        .MAX_FRAME_BYTES(FRAME_BYTES)
    ) u_envelope_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_if.valid),
        .i_cfg_ready  (cfg_if.ready),
        .i_cfg_payload(cfg_if.payload),
        .i_in_valid   (in_if.valid),
        .i_in_ready   (in_if.ready),
        .i_in_payload (in_if.payload),
        .i_out_valid  (out_if.valid),
        .i_out_ready  (out_if.ready),
        .i_out_payload(out_if.payload),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic logic [15:0] rand_duration();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_cfg random_settings();
        t_cfg s;
        case ($urandom_range(0, 5))
            0: s.frame_bits = 8'($urandom_range(1, 16));
            1: s.frame_bits = 8'($urandom_range(17, 127));
            2: s.frame_bits = 8'd128;
            3: s.frame_bits = 8'($urandom_range(129, 255));
            4: s.frame_bits = 8'd0;
            default: s.frame_bits = 8'(8 * $urandom_range(1, 4));
        endcase
        s.lsb_lead     = 1'($urandom_range(0, 1));
        s.header_mark  = ($urandom_range(0, 2) == 0) ? 16'd0 : rand_duration();
        s.header_space = rand_duration();
        s.mark_time    = rand_duration();
        s.one_space    = rand_duration();
        s.zero_space   = rand_duration();
        return s;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        int n;
        n = draw_wait();
        if (n > 0) begin
            cfg_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        cfg_if.payload <= '{reg_index: idx, wr_data: data};
        cfg_if.valid   <= 1'b1;
        do @(posedge i_clk); while (!(cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1));
    endtask

    task automatic apply_settings(input t_cfg s, input bit poke_unused);
        if (poke_unused) write_reg(REG_UNUSED, 16'($urandom));
        write_reg(REG_FRAME_BITS,   {8'($urandom), s.frame_bits});
        write_reg(REG_LSB_LEAD,     {15'($urandom), s.lsb_lead});
        write_reg(REG_HEADER_MARK,  s.header_mark);
        write_reg(REG_HEADER_SPACE, s.header_space);
        write_reg(REG_MARK_TIME,    s.mark_time);
        write_reg(REG_ONE_SPACE,    s.one_space);
        write_reg(REG_ZERO_SPACE,   s.zero_space);
        cfg_if.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_byte(input logic [7:0] data);
        int n;
        n = draw_wait();
        if (n > 0) begin
            in_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        in_if.payload <= '{data_byte: data};
        in_if.valid   <= 1'b1;
        do @(posedge i_clk); while (!(in_if.valid === 1'b1 && in_if.ready === 1'b1));
        bytes_sent++;
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int n;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            n = draw_wait();
            if (n > 0) begin
                out_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid === 1'b1 && out_if.ready === 1'b1));
        end
    end

    always @(posedge i_clk) begin
        if ((cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1) ||
            (in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_cfg s;
        int   burst;
        bit   first_phase;
        i_rst_n        <= 1'b0;
        cfg_if.valid   <= 1'b0;
        cfg_if.payload <= '0;
        in_if.valid    <= 1'b0;
        in_if.payload  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        send_byte(8'h5A);
        wait_drained();

        s = '{frame_bits: 8'd8, lsb_lead: 1'b0, header_mark: 16'd9000,
              header_space: 16'd4500, mark_time: 16'd0, one_space: 16'hFFFF,
              zero_space: 16'd0};
        apply_settings(s, 1'b1);
        send_byte(8'h80);
        send_byte(8'h01);
        wait_drained();

        s.frame_bits   = 8'd0;
        s.header_mark  = 16'd0;
        s.header_space = 16'hFFFF;
        apply_settings(s, 1'b0);
        send_byte(8'hFF);
        wait_drained();
        s.header_mark = 16'hFFFF;
        apply_settings(s, 1'b0);
        send_byte(8'h00);
        wait_drained();

        s = '{frame_bits: 8'd12, lsb_lead: 1'b0, header_mark: 16'd0,
              header_space: 16'd0, mark_time: 16'd560, one_space: 16'd1690,
              zero_space: 16'd560};
        apply_settings(s, 1'b0);
        send_byte(8'hC3);
        send_byte(8'h3C);
        wait_drained();
        s.lsb_lead = 1'b1;
        apply_settings(s, 1'b0);
        send_byte(8'hC3);
        send_byte(8'h3C);
        wait_drained();

        s.frame_bits  = 8'd20;
        s.header_mark = 16'd100;
        apply_settings(s, 1'b0);
        send_byte(8'h0F);
        send_byte(8'hF0);
        wait_drained();
        s.frame_bits = 8'd8;
        apply_settings(s, 1'b0);
        send_byte(8'h55);
        wait_drained();

        first_phase = 1'b1;
        while (bytes_sent < TARGET_BYTES) begin
            s = random_settings();
            if (first_phase) s.frame_bits = 8'hFF;
            first_phase = 1'b0;
            apply_settings(s, $urandom_range(0, 3) == 0);
            quiet = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(16, 40);
            repeat (burst) begin
                send_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 29) == 0) wait_drained();
            end
            wait_drained();
            quiet = 1'b0;
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d payload bytes under %0d register settings:", bytes_sent,
                 settings_used);
        $display("headers on and off, both bit orders, bit counts from 0 to 255.");
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
